FILE: rtl/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared types, register indexes and constants of the steepest descent
// direction block.
// ----------------------------------------------------------------------------
package sdd_pkg;

    // default sizes handed to the top level parameters
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int ELEV_BITS_DEF = 32;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIAG_WEIGHT = 2'd2;

    // register widths and reset values
    localparam int GRID_W_BITS = 11;
    localparam int GRID_H_BITS = 16;
    localparam int DIAG_BITS   = 16;
    localparam logic [GRID_W_BITS-1:0] GRID_WIDTH_RST  = 11'd1024;
    localparam logic [GRID_H_BITS-1:0] GRID_HEIGHT_RST = 16'd1024;
    localparam logic [DIAG_BITS-1:0]   DIAG_WEIGHT_RST = 16'd46341;

    // smallest grid side
    localparam int GRID_MIN = 5;

    // result fields
    localparam int ROW_W  = 16;
    localparam int COL_W  = 10;
    localparam int DIR_W  = 4;
    localparam int IDX_W  = 3;
    localparam int OUT_DW = 32;

    // neighbour codes, west first and clockwise
    localparam logic [DIR_W-1:0] DIR_W_CODE  = 4'd0;
    localparam logic [DIR_W-1:0] DIR_NW_CODE = 4'd1;
    localparam logic [DIR_W-1:0] DIR_N_CODE  = 4'd2;
    localparam logic [DIR_W-1:0] DIR_NE_CODE = 4'd3;
    localparam logic [DIR_W-1:0] DIR_E_CODE  = 4'd4;
    localparam logic [DIR_W-1:0] DIR_SE_CODE = 4'd5;
    localparam logic [DIR_W-1:0] DIR_S_CODE  = 4'd6;
    localparam logic [DIR_W-1:0] DIR_SW_CODE = 4'd7;
    localparam logic [DIR_W-1:0] DIR_NONE    = 4'd8;

    // window slot of each neighbour (3x3, row major, centre in slot 4)
    localparam int CENTRE_SLOT = 4;
    localparam logic [7:0][3:0] NB_SLOT = {4'd6, 4'd7, 4'd8, 4'd5,
                                           4'd2, 4'd1, 4'd0, 4'd3};

    // position information carried with each item
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             border;
        logic             last;
    } meta_t;

endpackage

FILE: rtl/sdd_ram.sv
// ----------------------------------------------------------------------------
// sdd_ram
// Generic simple dual port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sdd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sdd_window.sv
// ----------------------------------------------------------------------------
// sdd_window
// Raster position tracking, line memory read-modify-write and the 3x3
// window around the cell whose result is due.
// ----------------------------------------------------------------------------
module sdd_window #(
    parameter int MAX_WIDTH = sdd_pkg::MAX_WIDTH_DEF,
    parameter int ELEV_BITS = sdd_pkg::ELEV_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ELEV_BITS-1:0]            in_elev,
    input  logic                            in_frame_start,
    input  logic [sdd_pkg::GRID_W_BITS-1:0] grid_width,
    input  logic [sdd_pkg::GRID_H_BITS-1:0] grid_height,
    output logic                            win_valid,
    input  logic                            win_ready,
    output logic [8:0][ELEV_BITS-1:0]       win,
    output sdd_pkg::meta_t                  win_meta
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int GW = (WW > sdd_pkg::GRID_W_BITS) ? WW : sdd_pkg::GRID_W_BITS;
    localparam int HW = sdd_pkg::GRID_H_BITS;
    localparam int MW = 2 * ELEV_BITS;

    // position of the next cell
    logic [XW-1:0] col_reg;
    logic [HW-1:0] row_reg;

    // read stage: item waiting for its line memory data
    logic                 a_v_reg;
    logic [XW-1:0]        a_x_reg;
    logic [ELEV_BITS-1:0] a_cur_reg;
    logic                 a_prod_reg;
    sdd_pkg::meta_t       a_meta_reg;
    logic                 a_fwd_reg;
    logic [ELEV_BITS-1:0] fwd_up_reg;
    logic [ELEV_BITS-1:0] fwd_mid_reg;

    // window stage
    logic                       b_v_reg;
    logic                       b_prod_reg;
    sdd_pkg::meta_t             b_meta_reg;
    logic [8:0][ELEV_BITS-1:0]  win_reg;

    logic [GW-1:0]        w_eff;
    logic [HW-1:0]        h_eff;
    logic                 wrap;
    logic [XW-1:0]        x_cur;
    logic [HW-1:0]        y_cur;
    logic [GW-1:0]        x_ext;
    logic [GW-1:0]        c_ext;
    logic [HW-1:0]        r_cur;
    logic [GW-1:0]        x_inc;
    logic [HW:0]          y_inc;
    logic [XW-1:0]        col_next;
    logic [HW-1:0]        row_next;
    logic                 prod_next;
    sdd_pkg::meta_t       meta_next;
    logic                 accept;
    logic                 b_leave;
    logic                 b_free;
    logic                 a_adv;
    logic [MW-1:0]        ram_rdata;
    logic [ELEV_BITS-1:0] up_eff;
    logic [ELEV_BITS-1:0] mid_eff;

    // grid size clamped to the supported range
    always_comb
    begin
        priority if (GW'(grid_width) < GW'(sdd_pkg::GRID_MIN))
            w_eff = GW'(sdd_pkg::GRID_MIN);
        else if (GW'(grid_width) > GW'(MAX_WIDTH))
            w_eff = GW'(MAX_WIDTH);
        else
            w_eff = GW'(grid_width);
        if (grid_height < HW'(sdd_pkg::GRID_MIN))
            h_eff = HW'(sdd_pkg::GRID_MIN);
        else
            h_eff = grid_height;
    end

    // handshake through the two stages
    assign b_leave  = b_v_reg && (!b_prod_reg || win_ready);
    assign b_free   = !b_v_reg || b_leave;
    assign a_adv    = a_v_reg && b_free;
    assign in_ready = !a_v_reg || b_free;
    assign accept   = in_valid && in_ready;

    // position of the incoming cell and of the one after it
    always_comb
    begin
        wrap  = in_frame_start || (GW'(col_reg) >= w_eff) || (row_reg >= h_eff);
        x_cur = wrap ? '0 : col_reg;
        y_cur = wrap ? '0 : row_reg;
        x_ext = GW'(x_cur);
        c_ext = x_ext - GW'(1);
        r_cur = y_cur - HW'(1);
        x_inc = x_ext + GW'(1);
        y_inc = {1'b0, y_cur} + (HW + 1)'(1);
        prod_next = (x_ext >= GW'(2)) && (y_cur >= HW'(2));
        meta_next.row    = r_cur[sdd_pkg::ROW_W-1:0];
        meta_next.col    = c_ext[sdd_pkg::COL_W-1:0];
        meta_next.border = (r_cur == HW'(1)) || (r_cur == h_eff - HW'(2))
                        || (c_ext == GW'(1)) || (c_ext == w_eff - GW'(2));
        meta_next.last   = (r_cur == h_eff - HW'(2)) && (c_ext == w_eff - GW'(2));
        if (x_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (y_inc >= {1'b0, h_eff}) ? '0 : y_inc[HW-1:0];
        end
        else
        begin
            col_next = x_inc[XW-1:0];
            row_next = y_cur;
        end
    end

    // line memory: upper row in the high half, middle row in the low half
    sdd_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (a_adv),
        .waddr (a_x_reg),
        .wdata ({mid_eff, a_cur_reg}),
        .re    (accept),
        .raddr (x_cur),
        .rdata (ram_rdata)
    );

    // forwarded data when the entry was written in the cycle it was read
    assign up_eff  = a_fwd_reg ? fwd_up_reg  : ram_rdata[MW-1:ELEV_BITS];
    assign mid_eff = a_fwd_reg ? fwd_mid_reg : ram_rdata[ELEV_BITS-1:0];

    // position counters and read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            a_v_reg   <= 1'b0;
            a_fwd_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                a_v_reg   <= 1'b1;
                a_fwd_reg <= a_adv && (a_x_reg == x_cur);
            end
            else if (a_adv)
            begin
                a_v_reg <= 1'b0;
            end
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg     <= x_cur;
            a_cur_reg   <= in_elev;
            a_prod_reg  <= prod_next;
            a_meta_reg  <= meta_next;
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= a_cur_reg;
        end
    end

    // window shift, new column from the line memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg    <= 1'b0;
            b_prod_reg <= 1'b0;
            win_reg    <= '0;
        end
        else
        begin
            if (a_adv)
            begin
                b_v_reg    <= 1'b1;
                b_prod_reg <= a_prod_reg;
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2] <= up_eff;
                win_reg[5] <= mid_eff;
                win_reg[8] <= a_cur_reg;
            end
            else if (b_leave)
            begin
                b_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            b_meta_reg <= a_meta_reg;
        end
    end

    assign win_valid = b_v_reg && b_prod_reg;
    assign win       = win_reg;
    assign win_meta  = b_meta_reg;

endmodule

FILE: rtl/sdd_slope.sv
// ----------------------------------------------------------------------------
// sdd_slope
// Slopes to the eight neighbours, steepest selection over two stages and
// the result register.
// ----------------------------------------------------------------------------
module sdd_slope #(
    parameter int ELEV_BITS = sdd_pkg::ELEV_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          win_valid,
    output logic                          win_ready,
    input  logic [8:0][ELEV_BITS-1:0]     win,
    input  sdd_pkg::meta_t                win_meta,
    input  logic [sdd_pkg::DIAG_BITS-1:0] diag_weight,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sdd_pkg::DIR_W-1:0]     out_dir,
    output sdd_pkg::meta_t                out_meta
);

    localparam int SW = ELEV_BITS + sdd_pkg::DIAG_BITS;
    localparam int IW = sdd_pkg::IDX_W;

    // slope stage
    logic                 c_v_reg;
    logic [7:0][SW-1:0]   c_slope_reg;
    sdd_pkg::meta_t       c_meta_reg;
    logic [7:0][SW-1:0]   slope_next;

    // half selection stage
    logic                 d_v_reg;
    logic [1:0][SW-1:0]   d_best_reg;
    logic [1:0][IW-1:0]   d_idx_reg;
    sdd_pkg::meta_t       d_meta_reg;
    logic [1:0][SW-1:0]   best_next;
    logic [1:0][IW-1:0]   idx_next;

    // result stage
    logic                        o_v_reg;
    logic [sdd_pkg::DIR_W-1:0]   o_dir_reg;
    sdd_pkg::meta_t              o_meta_reg;
    logic [sdd_pkg::DIR_W-1:0]   dir_next;

    logic o_free;
    logic d_free;
    logic c_free;
    logic c_take;

    assign o_free    = !o_v_reg || out_ready;
    assign d_free    = !d_v_reg || o_free;
    assign c_free    = !c_v_reg || d_free;
    assign win_ready = c_free;
    assign c_take    = win_valid && c_free;

    // drop to each neighbour, scaled; a drop that is not positive gives zero
    always_comb
    begin
        logic [ELEV_BITS:0]   drop;
        logic [ELEV_BITS-1:0] mag;
        logic [ELEV_BITS-1:0] nb;
        logic [ELEV_BITS-1:0] centre;
        centre = win[sdd_pkg::CENTRE_SLOT];
        for (int n = 0; n < 8; n++)
        begin
            nb   = win[sdd_pkg::NB_SLOT[n]];
            drop = {centre[ELEV_BITS-1], centre} - {nb[ELEV_BITS-1], nb};
            mag  = drop[ELEV_BITS-1:0];
            if (drop[ELEV_BITS] || (drop == '0))
                slope_next[n] = '0;
            else if (n % 2 == 1)
                slope_next[n] = SW'(mag) * SW'(diag_weight);
            else
                slope_next[n] = {mag, {sdd_pkg::DIAG_BITS{1'b0}}};
        end
    end

    // steepest of each half; strict compare keeps the lowest index on a tie
    always_comb
    begin
        for (int g = 0; g < 2; g++)
        begin
            best_next[g] = c_slope_reg[g*4];
            idx_next[g]  = IW'(g * 4);
            for (int k = 1; k < 4; k++)
            begin
                if (c_slope_reg[g*4+k] > best_next[g])
                begin
                    best_next[g] = c_slope_reg[g*4+k];
                    idx_next[g]  = IW'(g * 4 + k);
                end
            end
        end
    end

    // final choice; border cells and flat or pit cells give no flow
    always_comb
    begin
        logic [SW-1:0] best;
        logic [IW-1:0] idx;
        if (d_best_reg[1] > d_best_reg[0])
        begin
            best = d_best_reg[1];
            idx  = d_idx_reg[1];
        end
        else
        begin
            best = d_best_reg[0];
            idx  = d_idx_reg[0];
        end
        if (d_meta_reg.border || (best == '0))
            dir_next = sdd_pkg::DIR_NONE;
        else
            dir_next = sdd_pkg::DIR_W'(idx);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (c_free)
                c_v_reg <= win_valid;
            if (d_free)
                d_v_reg <= c_v_reg;
            if (o_free)
                o_v_reg <= d_v_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (c_take)
        begin
            c_slope_reg <= slope_next;
            c_meta_reg  <= win_meta;
        end
        if (c_v_reg && d_free)
        begin
            d_best_reg <= best_next;
            d_idx_reg  <= idx_next;
            d_meta_reg <= c_meta_reg;
        end
        if (d_v_reg && o_free)
        begin
            o_dir_reg  <= dir_next;
            o_meta_reg <= d_meta_reg;
        end
    end

    assign out_valid = o_v_reg;
    assign out_dir   = o_dir_reg;
    assign out_meta  = o_meta_reg;

endmodule

FILE: rtl/d8_steepest_descent_direction.sv
// ----------------------------------------------------------------------------
// d8_steepest_descent_direction
// Streaming D8 flow direction over a raster of signed Q16.16 elevations.
// ----------------------------------------------------------------------------
// The block takes one raster cell per cycle in row order unless the
// output stalls, and returns, for every cell inside the outer ring, the
// direction to its steepest downhill neighbour (0 W, 1 NW, 2 N, 3 NE,
// 4 E, 5 SE, 6 S, 7 SW, 8 no flow). Each cell does one read and one write
// of the shared line memory (both rows held side by side in one entry),
// and that single memory pass per cell sets the pace. Cell (r,c) resolves
// as cell (r+1,c+1) passes the read, window, slope, half selection and
// result registers. Cells of the second ring always give 8. Diagonal
// drops are scaled by diag_weight (Q0.16). The line memory is never
// cleared; a frame needs no gap before it, and no start-up pass follows
// reset. Registers may only be written while the block holds no item.
module d8_steepest_descent_direction #(
    parameter int MAX_WIDTH = sdd_pkg::MAX_WIDTH_DEF,
    parameter int ELEV_BITS = sdd_pkg::ELEV_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_we,
    input  logic [sdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sdd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // cells in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((ELEV_BITS+7)/8)*8-1:0]   s_tdata,   // elevation
    input  logic [0:0]                       s_tuser,   // frame_start
    // directions out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sdd_pkg::OUT_DW-1:0]       m_tdata,   // cell_row, cell_col, direction
    output logic                             m_tlast    // is_last
);

    localparam int PAD_W = sdd_pkg::OUT_DW - sdd_pkg::ROW_W - sdd_pkg::COL_W
                         - sdd_pkg::DIR_W;

    logic [sdd_pkg::GRID_W_BITS-1:0] grid_width_reg;
    logic [sdd_pkg::GRID_H_BITS-1:0] grid_height_reg;
    logic [sdd_pkg::DIAG_BITS-1:0]   diag_weight_reg;

    logic                            win_valid;
    logic                            win_ready;
    logic [8:0][ELEV_BITS-1:0]       win;
    sdd_pkg::meta_t                  win_meta;
    logic [sdd_pkg::DIR_W-1:0]       out_dir;
    sdd_pkg::meta_t                  out_meta;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= sdd_pkg::GRID_WIDTH_RST;
            grid_height_reg <= sdd_pkg::GRID_HEIGHT_RST;
            diag_weight_reg <= sdd_pkg::DIAG_WEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sdd_pkg::CFG_GRID_WIDTH:
                    grid_width_reg <= cfg_data[sdd_pkg::GRID_W_BITS-1:0];
                sdd_pkg::CFG_GRID_HEIGHT:
                    grid_height_reg <= cfg_data[sdd_pkg::GRID_H_BITS-1:0];
                sdd_pkg::CFG_DIAG_WEIGHT:
                    diag_weight_reg <= cfg_data[sdd_pkg::DIAG_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // position tracking, line memory and window
    sdd_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .ELEV_BITS (ELEV_BITS)
    ) u_window (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_elev        (s_tdata[ELEV_BITS-1:0]),
        .in_frame_start (s_tuser[0]),
        .grid_width     (grid_width_reg),
        .grid_height    (grid_height_reg),
        .win_valid      (win_valid),
        .win_ready      (win_ready),
        .win            (win),
        .win_meta       (win_meta)
    );

    // slopes and steepest selection
    sdd_slope #(
        .ELEV_BITS (ELEV_BITS)
    ) u_slope (
        .clk         (clk),
        .rst_n       (rst_n),
        .win_valid   (win_valid),
        .win_ready   (win_ready),
        .win         (win),
        .win_meta    (win_meta),
        .diag_weight (diag_weight_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_dir     (out_dir),
        .out_meta    (out_meta)
    );

    // result item packing
    assign m_tdata = {{PAD_W{1'b0}}, out_dir, out_meta.col, out_meta.row};
    assign m_tlast = out_meta.last;

    // input backpressure only ever comes from a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output side is free");

    // the last cell of a frame lies on the second ring
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (out_dir == sdd_pkg::DIR_NONE))
        else $error("last result of frame carries a flow direction");

    // direction code within range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_dir <= sdd_pkg::DIR_NONE))
        else $error("direction code out of range");

endmodule
